FILE: rtl/spc_pkg.sv
`default_nettype none

package spc_pkg;

   // Default size of the sector buffer in bytes.
   localparam int SECTOR_BYTES_DEFAULT = 512;

   // Configuration register reset values.
   localparam logic [4:0] INIT_POLL_RESET  = 5'd16;
   localparam logic [3:0] READY_POLL_RESET = 4'd3;

   // Configuration register indexes.
   localparam logic REG_INIT_POLL  = 1'b0;
   localparam logic REG_READY_POLL = 1'b1;

   // Operation codes of an input transaction.
   localparam logic [2:0] OP_DATA_WR = 3'd0;
   localparam logic [2:0] OP_CTRL_WR = 3'd1;
   localparam logic [2:0] OP_ADDR_WR = 3'd2;
   localparam logic [2:0] OP_DATA_RD = 3'd3;
   localparam logic [2:0] OP_STAT_RD = 3'd4;
   localparam logic [2:0] OP_MOUNT   = 3'd5;
   localparam logic [2:0] OP_FILL    = 3'd6;
   localparam logic [2:0] OP_DRAIN   = 3'd7;

   // Controller modes.
   localparam logic [2:0] MODE_NOIMG = 3'd0;
   localparam logic [2:0] MODE_INIT  = 3'd1;
   localparam logic [2:0] MODE_IDLE  = 3'd2;
   localparam logic [2:0] MODE_READ  = 3'd3;
   localparam logic [2:0] MODE_WRITE = 3'd4;

   // Command bytes.
   localparam logic [7:0] CMD_READ  = 8'd0;
   localparam logic [7:0] CMD_WRITE = 8'd1;

   // Block address byte selects.
   localparam logic [1:0] SEL_LOW  = 2'd0;
   localparam logic [1:0] SEL_MID  = 2'd1;
   localparam logic [1:0] SEL_HIGH = 2'd2;

   // Error codes.
   localparam logic [3:0] ERR_NONE         = 4'd0;
   localparam logic [3:0] ERR_WR_NOT_WRITE = 4'd1;
   localparam logic [3:0] ERR_WR_BUSY      = 4'd2;
   localparam logic [3:0] ERR_CMD_NOIMG    = 4'd3;
   localparam logic [3:0] ERR_CMD_INIT     = 4'd4;
   localparam logic [3:0] ERR_CMD_READING  = 4'd5;
   localparam logic [3:0] ERR_CMD_WRITING  = 4'd6;
   localparam logic [3:0] ERR_CMD_UNKNOWN  = 4'd7;
   localparam logic [3:0] ERR_RD_NOT_READY = 4'd8;
   localparam logic [3:0] ERR_RD_WRITING   = 4'd9;
   localparam logic [3:0] ERR_BAD_INDEX    = 4'd10;
   localparam logic [3:0] ERR_OVERRUN      = 4'd11;

   // Status bytes and the idle data read value.
   localparam logic [7:0] STAT_NOIMG    = 8'h90;
   localparam logic [7:0] STAT_IDLE     = 8'h80;
   localparam logic [7:0] STAT_RD_READY = 8'hE0;
   localparam logic [7:0] STAT_RD_WAIT  = 8'hA0;
   localparam logic [7:0] STAT_WR_READY = 8'hA0;
   localparam logic [7:0] STAT_WR_WAIT  = 8'h20;
   localparam logic [7:0] DATA_NONE     = 8'hFF;

   typedef struct packed {
      logic [4:0] init_poll;
      logic [3:0] ready_poll;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/spc_sector_ram.sv
`default_nettype none

module spc_sector_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/spc_csr.sv
`default_nettype none

module spc_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [2:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output logic      [31:0]     prdata,
   output logic                 pready,
   output spc_pkg::cfg_type     cfg
);

   import spc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_stb;

   // The register index sits in address bit two; the byte lanes are ignored.
   assign wr_stb = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         if (paddr[2] == REG_INIT_POLL) begin
            cfg_in.init_poll = pwdata[4:0];
         end else begin
            cfg_in.ready_poll = pwdata[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_poll  <= INIT_POLL_RESET;
         cfg_ff.ready_poll <= READY_POLL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      if (paddr[2] == REG_INIT_POLL) begin
         prdata = {27'd0, cfg_ff.init_poll};
      end else begin
         prdata = {28'd0, cfg_ff.ready_poll};
      end
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/spc_core.sv
`default_nettype none

module spc_core #(
   parameter int SECTOR_BYTES = 512,
   parameter int AW           = 9,
   parameter int PW           = 10
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire spc_pkg::cfg_type cfg,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [2:0]      req_op,
   input  wire logic [7:0]      req_wdata,
   input  wire logic [1:0]      req_addr_byte_sel,
   input  wire logic [8:0]      req_buf_index,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic      [7:0]      rsp_rdata,
   output logic      [3:0]      rsp_error_code,
   output logic                 rsp_fetch_request,
   output logic                 rsp_commit_request,
   output logic      [23:0]     rsp_block_addr,
   output logic                 ram_wr_en,
   output logic      [AW-1:0]   ram_wr_addr,
   output logic      [7:0]      ram_wr_data,
   output logic                 ram_rd_en,
   output logic      [AW-1:0]   ram_rd_addr,
   input  wire logic [7:0]      ram_rd_data
);

   import spc_pkg::*;

   localparam logic PH_ACCEPT = 1'b0;
   localparam logic PH_EXEC   = 1'b1;
   localparam logic [PW-1:0] LAST_POS = PW'(SECTOR_BYTES);

   logic          phase_ff, phase_in;
   logic [2:0]    mode_ff, mode_in;
   logic [4:0]    poll_ff, poll_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [23:0]   lba_ff, lba_in;

   logic [2:0]    item_op_ff;
   logic [7:0]    item_wdata_ff;
   logic [1:0]    item_sel_ff;
   logic [8:0]    item_bidx_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rdata_ff, rdata_in;
   logic [3:0]    err_ff, err_in;
   logic          fetch_ff, fetch_in;
   logic          commit_ff, commit_in;

   logic          accept;
   logic          done;
   logic          is_ready;
   logic          rdy_after;
   logic [4:0]    poll_step;
   logic [4:0]    ready_ext;
   logic          pos_ok;
   logic          item_bidx_ok;
   logic [31:0]   item_bidx_wide;
   logic [31:0]   req_bidx_wide;

   assign req_ready = (phase_ff == PH_ACCEPT);
   assign accept    = req_valid && req_ready;
   assign done      = (phase_ff == PH_EXEC) && (!rsp_valid_ff || rsp_ready);

   // Buffer read is issued as the transaction is taken, so the byte is
   // waiting when the execute cycle runs.
   assign req_bidx_wide = 32'(req_buf_index);
   assign ram_rd_en     = accept && (req_op == OP_DATA_RD || req_op == OP_DRAIN);
   assign ram_rd_addr   = (req_op == OP_DATA_RD) ? pos_ff[AW-1:0] : req_bidx_wide[AW-1:0];

   always_ff @(posedge clock) begin
      if (accept) begin
         item_op_ff    <= req_op;
         item_wdata_ff <= req_wdata;
         item_sel_ff   <= req_addr_byte_sel;
         item_bidx_ff  <= req_buf_index;
      end
   end

   assign ready_ext      = {1'b0, cfg.ready_poll};
   assign is_ready       = poll_ff >= ready_ext;
   assign poll_step      = poll_ff + 5'd1;
   assign pos_ok         = 32'(pos_ff) < 32'(SECTOR_BYTES);
   assign item_bidx_wide = 32'(item_bidx_ff);
   assign item_bidx_ok   = item_bidx_wide < 32'(SECTOR_BYTES);

   always_comb begin
      mode_in     = mode_ff;
      poll_in     = poll_ff;
      pos_in      = pos_ff;
      lba_in      = lba_ff;
      rdata_in    = 8'd0;
      err_in      = ERR_NONE;
      fetch_in    = 1'b0;
      commit_in   = 1'b0;
      rdy_after   = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_ff[AW-1:0];
      ram_wr_data = item_wdata_ff;
      case (item_op_ff)
         OP_DATA_WR: begin
            if (mode_ff != MODE_WRITE) begin
               err_in = ERR_WR_NOT_WRITE;
            end else if (!is_ready) begin
               err_in = ERR_WR_BUSY;
            end else begin
               poll_in = 5'd0;
               if (pos_ok) begin
                  ram_wr_en = done;
                  pos_in    = pos_ff + PW'(1);
                  if (pos_in == LAST_POS) begin
                     mode_in   = MODE_IDLE;
                     commit_in = 1'b1;
                  end
               end else begin
                  err_in = ERR_OVERRUN;
               end
            end
         end
         OP_CTRL_WR: begin
            case (mode_ff)
               MODE_NOIMG: err_in = ERR_CMD_NOIMG;
               MODE_INIT:  err_in = ERR_CMD_INIT;
               MODE_READ:  err_in = ERR_CMD_READING;
               MODE_WRITE: err_in = ERR_CMD_WRITING;
               default: begin
                  poll_in = 5'd0;
                  if (item_wdata_ff == CMD_READ) begin
                     mode_in  = MODE_READ;
                     pos_in   = '0;
                     fetch_in = 1'b1;
                  end else if (item_wdata_ff == CMD_WRITE) begin
                     mode_in = MODE_WRITE;
                     pos_in  = '0;
                  end else begin
                     err_in = ERR_CMD_UNKNOWN;
                  end
               end
            endcase
         end
         OP_ADDR_WR: begin
            case (item_sel_ff)
               SEL_LOW:  lba_in[7:0]   = item_wdata_ff;
               SEL_MID:  lba_in[15:8]  = item_wdata_ff;
               SEL_HIGH: lba_in[23:16] = item_wdata_ff;
               default:  lba_in        = lba_ff;
            endcase
         end
         OP_DATA_RD: begin
            rdata_in = DATA_NONE;
            if (mode_ff == MODE_READ) begin
               if (!is_ready) begin
                  err_in = ERR_RD_NOT_READY;
               end else begin
                  poll_in = 5'd0;
                  if (pos_ff + PW'(1) == LAST_POS) begin
                     mode_in = MODE_IDLE;
                  end
                  if (pos_ok) begin
                     rdata_in = ram_rd_data;
                     pos_in   = pos_ff + PW'(1);
                  end else begin
                     err_in = ERR_OVERRUN;
                  end
               end
            end else if (mode_ff == MODE_WRITE) begin
               err_in = ERR_RD_WRITING;
            end
         end
         OP_STAT_RD: begin
            case (mode_ff)
               MODE_NOIMG: rdata_in = STAT_NOIMG;
               MODE_INIT: begin
                  poll_in  = poll_step;
                  rdata_in = STAT_NOIMG;
                  if (poll_step >= cfg.init_poll) begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_IDLE: rdata_in = STAT_IDLE;
               MODE_READ, MODE_WRITE: begin
                  if (!is_ready) begin
                     poll_in   = poll_step;
                     rdy_after = poll_step >= ready_ext;
                  end
                  if (mode_ff == MODE_READ) begin
                     rdata_in = rdy_after ? STAT_RD_READY : STAT_RD_WAIT;
                  end else begin
                     rdata_in = rdy_after ? STAT_WR_READY : STAT_WR_WAIT;
                  end
               end
               default: rdata_in = 8'd0;
            endcase
         end
         OP_MOUNT: begin
            mode_in = MODE_INIT;
         end
         OP_FILL: begin
            ram_wr_addr = item_bidx_wide[AW-1:0];
            if (item_bidx_ok) begin
               ram_wr_en = done;
            end else begin
               err_in = ERR_BAD_INDEX;
            end
         end
         default: begin
            if (item_bidx_ok) begin
               rdata_in = ram_rd_data;
            end else begin
               err_in = ERR_BAD_INDEX;
            end
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         phase_in = PH_EXEC;
      end else if (done) begin
         phase_in = PH_ACCEPT;
      end
   end

   always_comb begin
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ACCEPT;
         mode_ff      <= MODE_NOIMG;
         poll_ff      <= 5'd0;
         pos_ff       <= '0;
         lba_ff       <= 24'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done) begin
            mode_ff <= mode_in;
            poll_ff <= poll_in;
            pos_ff  <= pos_in;
            lba_ff  <= lba_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rdata_ff  <= rdata_in;
         err_ff    <= err_in;
         fetch_ff  <= fetch_in;
         commit_ff <= commit_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rdata          = rdata_ff;
   assign rsp_error_code     = err_ff;
   assign rsp_fetch_request  = fetch_ff;
   assign rsp_commit_request = commit_ff;
   assign rsp_block_addr     = lba_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) <= 32'(SECTOR_BYTES))
      else $error("Byte position has run past the end of the sector.");

   a_wr_only_exec: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (phase_ff == PH_EXEC) && (item_op_ff == OP_DATA_WR || item_op_ff == OP_FILL))
      else $error("Buffer written outside the execute cycle of a write or fill.");

   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      (done && commit_in) |=> (mode_ff == MODE_IDLE) && (pos_ff == LAST_POS))
      else $error("Commit raised without the sector being complete.");

   a_fetch_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(fetch_ff && commit_ff))
      else $error("Fetch and commit requested by the same transaction.");

   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("New transaction taken while one is still executing.");

endmodule

`default_nettype wire

FILE: rtl/sd_sector_port_controller.sv
// Sequencing: a request transaction is taken in the accept phase, then the
// execute phase registers its response once the response slot is free.
// A new transaction is taken only after the previous one has executed; the
// sector buffer read is issued as a transaction is taken, ahead of execute.
// Reset: synchronous and active high; mode, counters and block address are
// cleared, the configuration registers return to their reset values, and the
// sector buffer keeps its contents.
`default_nettype none

module sd_sector_port_controller #(
   parameter int SECTOR_BYTES = spc_pkg::SECTOR_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration port.
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   // Request channel.
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_op,
   input  wire logic [7:0]  req_wdata,
   input  wire logic [1:0]  req_addr_byte_sel,
   input  wire logic [8:0]  req_buf_index,
   // Response channel.
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_rdata,
   output logic      [3:0]  rsp_error_code,
   output logic             rsp_fetch_request,
   output logic             rsp_commit_request,
   output logic      [23:0] rsp_block_addr
);

   import spc_pkg::*;

   // The buffer address covers the sector; the byte position must also be
   // able to hold the sector length itself once the last byte has moved.
   localparam int AW = $clog2(SECTOR_BYTES);
   localparam int PW = AW + 1;

   cfg_type       cfg;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   // The configuration registers hold the two poll thresholds. Writes are
   // expected only while no transaction is in flight.
   spc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The sector buffer is a simple dual-port memory with a registered read.
   // Its contents are not defined until a fill or a data write reaches them.
   spc_sector_ram #(
      .DEPTH (SECTOR_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The core takes one transaction, reads the buffer in the same cycle,
   // then in its execute cycle updates mode, poll counter, byte position and
   // block address, writes the buffer where needed and loads the response
   // register. As a transaction is only taken once the previous one has
   // finished executing, a buffer write always lands before the next read.
   spc_core #(
      .SECTOR_BYTES (SECTOR_BYTES),
      .AW           (AW),
      .PW           (PW)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_wdata          (req_wdata),
      .req_addr_byte_sel  (req_addr_byte_sel),
      .req_buf_index      (req_buf_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rdata          (rsp_rdata),
      .rsp_error_code     (rsp_error_code),
      .rsp_fetch_request  (rsp_fetch_request),
      .rsp_commit_request (rsp_commit_request),
      .rsp_block_addr     (rsp_block_addr),
      .ram_wr_en          (ram_wr_en),
      .ram_wr_addr        (ram_wr_addr),
      .ram_wr_data        (ram_wr_data),
      .ram_rd_en          (ram_rd_en),
      .ram_rd_addr        (ram_rd_addr),
      .ram_rd_data        (ram_rd_data)
   );

endmodule

`default_nettype wire
